[rtl/ffd_bilinear_vertex_warp_unit_defines.svh]
// Assertion macros shared by the warp unit RTL.
`ifndef FFD_BILINEAR_VERTEX_WARP_UNIT_DEFINES_SVH
`define FFD_BILINEAR_VERTEX_WARP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define FFD_ASSERT_IMPL(name, clk, rstn, cond, check) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (check)) \
        else $error("ffd warp unit: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define FFD_ASSERT_NEXT(name, clk, rstn, cond, check) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (check)) \
        else $error("ffd warp unit: next-cycle check failed");
`else
`define FFD_ASSERT_IMPL(name, clk, rstn, cond, check)
`define FFD_ASSERT_NEXT(name, clk, rstn, cond, check)
`endif

`endif

[rtl/ffd_pkg.sv]
// Package with field widths, codes and defaults of the bilinear vertex warp unit.
package ffd_pkg;

    // Default grid limits.
    localparam int DEFAULT_MAX_COLUMNS = 16;
    localparam int DEFAULT_MAX_ROWS    = 16;

    // Field widths.
    localparam int PIDX_W   = 8;
    localparam int OFS_W    = 20;
    localparam int POS_W    = 24;
    localparam int COORD_W  = 17;
    localparam int WEIGHT_W = 17;
    localparam int SIZE_W   = 5;
    localparam int FRAC_W   = 16;
    localparam int ENTRY_W  = 2 * OFS_W;

    // One in unsigned Q1.16, and the smallest grid dimension.
    localparam int Q16_ONE      = 65536;
    localparam int MIN_GRID_DIM = 2;

    // Reachable control-point indexes.
    localparam int INDEX_SPACE = 2 ** PIDX_W;

    // Input tdata layout, lowest field first.
    localparam int TD_PIDX_LSB = 0;
    localparam int TD_OFSX_LSB = TD_PIDX_LSB + PIDX_W;
    localparam int TD_OFSY_LSB = TD_OFSX_LSB + OFS_W;
    localparam int TD_POSX_LSB = TD_OFSY_LSB + OFS_W;
    localparam int TD_POSY_LSB = TD_POSX_LSB + POS_W;
    localparam int TD_U_LSB    = TD_POSY_LSB + POS_W;
    localparam int TD_V_LSB    = TD_U_LSB + COORD_W;
    localparam int S_TDATA_W   = ((TD_V_LSB + COORD_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 2 * POS_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_GRID_COLUMNS  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEFORM_WEIGHT = 2'd2;

    // Item operations.
    typedef enum logic [S_TUSER_W-1:0] {
        OP_DEFORM = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

endpackage

[rtl/ffd_bilinear_vertex_warp_unit.sv]
// Bilinear free-form warp unit: a grid of control-point offsets deforms a stream of vertices.
// Items arrive on s_axis with the operation in tuser: a deform item returns one result on
// m_axis, a write item stores one control-point offset, a clear item zeroes the grid. The
// unit takes one item per cycle and a deform result reaches the output register after
// acceptance through clamp, grid scaling, neighbor index, grid memory read, horizontal blend,
// vertical blend, weighting and the saturating add, which each take one register stage, and
// the ready chain collapses bubbles so that the input stalls only when every stage is full.
// The grid lives in two copies of a memory with two read ports each, so the four neighbors
// are read in a single cycle; per-entry valid flags make a clear, or a write to grid_columns
// or grid_rows, take effect at once with no sweep. Write items are applied at the memory
// stage in stream order, so a deform item always sees every earlier write.
`include "ffd_bilinear_vertex_warp_unit_defines.svh"

module ffd_bilinear_vertex_warp_unit
    import ffd_pkg::*;
#(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEFAULT_MAX_ROWS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // point_index, offset_x, offset_y, pos_x, pos_y, coord_u, coord_v, zero fill
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    // Result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // new_x, new_y
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int CELL_W  = COL_W + ROW_W;
    localparam int FX_W    = COORD_W + COL_W;
    localparam int FY_W    = COORD_W + ROW_W;
    localparam int IDX_W   = $clog2(MAX_COLUMNS * MAX_ROWS);
    localparam int DEPTH   = (MAX_COLUMNS * MAX_ROWS < INDEX_SPACE) ?
                             MAX_COLUMNS * MAX_ROWS : INDEX_SPACE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DIFF_W  = OFS_W + 1;
    localparam int P1_W    = DIFF_W + FRAC_W + 1;
    localparam int LERP_W  = OFS_W + FRAC_W;
    localparam int P2_W    = LERP_W + 1 + FRAC_W + 1;
    localparam int E_W     = LERP_W + WEIGHT_W + 1;
    localparam int DELTA_W = E_W - 2 * FRAC_W;
    localparam int CMP_W   = 8;
    localparam int WR_CMP_W = (CELL_W > PIDX_W) ? CELL_W : PIDX_W;

    localparam logic [E_W-1:0] ROUND_HALF = E_W'(1) << (2 * FRAC_W - 1);

    // Stage payloads.
    typedef struct packed {
        op_t                       op;
        logic [PIDX_W-1:0]         pidx;
        logic [OFS_W-1:0]          ofs_x;
        logic [OFS_W-1:0]          ofs_y;
        logic [POS_W-1:0]          pos_x;
        logic [POS_W-1:0]          pos_y;
        logic [COORD_W-1:0]        u;
        logic [COORD_W-1:0]        v;
    } st1_t;

    typedef struct packed {
        op_t                       op;
        logic [PIDX_W-1:0]         pidx;
        logic [OFS_W-1:0]          ofs_x;
        logic [OFS_W-1:0]          ofs_y;
        logic                      wr_ok;
        logic [POS_W-1:0]          pos_x;
        logic [POS_W-1:0]          pos_y;
        logic [FX_W-1:0]           fx;
        logic [FY_W-1:0]           fy;
    } st2_t;

    typedef struct packed {
        op_t                       op;
        logic [PIDX_W-1:0]         pidx;
        logic [OFS_W-1:0]          ofs_x;
        logic [OFS_W-1:0]          ofs_y;
        logic                      wr_ok;
        logic [POS_W-1:0]          pos_x;
        logic [POS_W-1:0]          pos_y;
        logic [FRAC_W-1:0]         tx;
        logic [FRAC_W-1:0]         ty;
        logic [3:0][IDX_W-1:0]     idx;
    } st3_t;

    typedef struct packed {
        logic [POS_W-1:0]          pos_x;
        logic [POS_W-1:0]          pos_y;
        logic [FRAC_W-1:0]         tx;
        logic [FRAC_W-1:0]         ty;
    } st4_t;

    typedef struct packed {
        logic [POS_W-1:0]          pos_x;
        logic [POS_W-1:0]          pos_y;
        logic [FRAC_W-1:0]         ty;
        logic [LERP_W-1:0]         ax;
        logic [LERP_W-1:0]         bx;
        logic [LERP_W-1:0]         ay;
        logic [LERP_W-1:0]         by;
    } st5_t;

    typedef struct packed {
        logic [POS_W-1:0]          pos_x;
        logic [POS_W-1:0]          pos_y;
        logic [LERP_W-1:0]         dx;
        logic [LERP_W-1:0]         dy;
    } st6_t;

    typedef struct packed {
        logic [POS_W-1:0]          pos_x;
        logic [POS_W-1:0]          pos_y;
        logic [DELTA_W-1:0]        delta_x;
        logic [DELTA_W-1:0]        delta_y;
    } st7_t;

    // Horizontal blend: lo * (1 - t) + hi * t, kept exact with 16 fraction bits.
    function automatic logic [LERP_W-1:0] blend_h(input logic [OFS_W-1:0] lo,
                                                  input logic [OFS_W-1:0] hi,
                                                  input logic [FRAC_W-1:0] t);
        logic signed [DIFF_W-1:0] diff;
        logic signed [P1_W-1:0]   prod;
        logic [P1_W-1:0]          base;
        logic [P1_W-1:0]          sum;
        diff = $signed({hi[OFS_W-1], hi}) - $signed({lo[OFS_W-1], lo});
        prod = diff * $signed({1'b0, t});
        base = {{(P1_W - LERP_W){lo[OFS_W-1]}}, lo, {FRAC_W{1'b0}}};
        sum  = base + prod;
        return sum[LERP_W-1:0];
    endfunction

    // Vertical blend with the 16 low fraction bits floored away.
    function automatic logic [LERP_W-1:0] blend_v(input logic [LERP_W-1:0] a,
                                                  input logic [LERP_W-1:0] b,
                                                  input logic [FRAC_W-1:0] t);
        logic signed [LERP_W:0]   diff;
        logic signed [P2_W-1:0]   prod;
        logic [P2_W-FRAC_W-1:0]   sum;
        diff = $signed({b[LERP_W-1], b}) - $signed({a[LERP_W-1], a});
        prod = diff * $signed({1'b0, t});
        sum  = {{(P2_W - FRAC_W - LERP_W){a[LERP_W-1]}}, a} + prod[P2_W-1:FRAC_W];
        return sum[LERP_W-1:0];
    endfunction

    // Weighting with round half up on the 32 fraction bits.
    function automatic logic [DELTA_W-1:0] apply_weight(input logic [LERP_W-1:0] d,
                                                        input logic [WEIGHT_W-1:0] w);
        logic signed [E_W-1:0] e;
        logic [E_W-1:0]        er;
        e  = $signed(d) * $signed({1'b0, w});
        er = e + ROUND_HALF;
        return er[E_W-1:2*FRAC_W];
    endfunction

    // Position plus offset, saturated to the position range.
    function automatic logic [POS_W-1:0] add_sat(input logic [POS_W-1:0] pos,
                                                 input logic [DELTA_W-1:0] delta);
        logic [POS_W:0] sum;
        sum = {pos[POS_W-1], pos} + {{(POS_W + 1 - DELTA_W){delta[DELTA_W-1]}}, delta};
        if (sum[POS_W] != sum[POS_W-1]) begin
            return sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        return sum[POS_W-1:0];
    endfunction

    // Configuration registers and their effective values.
    logic [SIZE_W-1:0]   cols_reg;
    logic [SIZE_W-1:0]   rows_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                cfg_wr;
    logic                size_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [CMP_W-1:0]    cols_raw;
    logic [CMP_W-1:0]    rows_raw;
    logic [CMP_W-1:0]    cols_clamp;
    logic [CMP_W-1:0]    rows_clamp;
    logic [COL_W-1:0]    cols_eff;
    logic [ROW_W-1:0]    rows_eff;
    logic [COL_W-1:0]    cols_m1;
    logic [ROW_W-1:0]    rows_m1;
    logic [CELL_W-1:0]   cell_count;
    logic [WEIGHT_W-1:0] weight_eff;

    // Pipeline registers and handshakes.
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic p5_valid_reg, p6_valid_reg, p7_valid_reg, out_valid_reg;
    logic p1_adv, p2_adv, p3_adv, p4_adv, p5_adv, p6_adv, p7_adv, out_adv;
    st1_t p1_reg, p1_next;
    st2_t p2_reg, p2_next;
    st3_t p3_reg, p3_next;
    st4_t p4_reg, p4_next;
    st5_t p5_reg, p5_next;
    st6_t p6_reg, p6_next;
    st7_t p7_reg, p7_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    // Grid storage.
    logic [ENTRY_W-1:0]   grid_mem_a [DEPTH];
    logic [ENTRY_W-1:0]   grid_mem_b [DEPTH];
    logic [DEPTH-1:0]     grid_valid_reg;
    logic [ENTRY_W-1:0]   rd_reg [4];
    logic [3:0]           hit_reg;
    logic [ADDR_W-1:0]    rd_addr [4];
    logic [3:0]           rd_in_range;
    logic [ADDR_W-1:0]    p3_waddr;
    logic [ENTRY_W-1:0]   wr_entry;
    logic                 write_fire;
    logic                 clear_fire;
    logic [OFS_W-1:0]     nb_x [4];
    logic [OFS_W-1:0]     nb_y [4];

    // Configuration port access.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign size_wr = cfg_wr && ((cfg_idx == REG_GRID_COLUMNS) || (cfg_idx == REG_GRID_ROWS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg   <= SIZE_W'(MIN_GRID_DIM);
            rows_reg   <= SIZE_W'(MIN_GRID_DIM);
            weight_reg <= WEIGHT_W'(Q16_ONE);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GRID_COLUMNS:  cols_reg   <= pwdata[SIZE_W-1:0];
                REG_GRID_ROWS:     rows_reg   <= pwdata[SIZE_W-1:0];
                REG_DEFORM_WEIGHT: weight_reg <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GRID_COLUMNS:  prdata = CFG_DATA_W'(cols_reg);
            REG_GRID_ROWS:     prdata = CFG_DATA_W'(rows_reg);
            REG_DEFORM_WEIGHT: prdata = CFG_DATA_W'(weight_reg);
            default:           prdata = '0;
        endcase
    end

    // Grid size clamped to the supported range, and the weight clamped to one.
    assign cols_raw   = CMP_W'(cols_reg);
    assign rows_raw   = CMP_W'(rows_reg);
    assign cols_clamp = (cols_raw < CMP_W'(MIN_GRID_DIM)) ? CMP_W'(MIN_GRID_DIM) :
                        (cols_raw > CMP_W'(MAX_COLUMNS))  ? CMP_W'(MAX_COLUMNS)  : cols_raw;
    assign rows_clamp = (rows_raw < CMP_W'(MIN_GRID_DIM)) ? CMP_W'(MIN_GRID_DIM) :
                        (rows_raw > CMP_W'(MAX_ROWS))     ? CMP_W'(MAX_ROWS)     : rows_raw;
    assign cols_eff   = cols_clamp[COL_W-1:0];
    assign rows_eff   = rows_clamp[ROW_W-1:0];
    assign cols_m1    = cols_eff - COL_W'(1);
    assign rows_m1    = rows_eff - ROW_W'(1);
    assign cell_count = CELL_W'(cols_eff) * CELL_W'(rows_eff);
    assign weight_eff = (weight_reg > WEIGHT_W'(Q16_ONE)) ? WEIGHT_W'(Q16_ONE) : weight_reg;

    // Ready chain: a stage loads when it is empty or its content moves on.
    assign out_adv = !out_valid_reg || m_axis_tready;
    assign p7_adv  = !p7_valid_reg || out_adv;
    assign p6_adv  = !p6_valid_reg || p7_adv;
    assign p5_adv  = !p5_valid_reg || p6_adv;
    assign p4_adv  = !p4_valid_reg || p5_adv;
    assign p3_adv  = !p3_valid_reg || p4_adv;
    assign p2_adv  = !p2_valid_reg || p3_adv;
    assign p1_adv  = !p1_valid_reg || p2_adv;

    assign s_axis_tready = p1_adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Valid bits; only deform items continue past the memory stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            p6_valid_reg  <= 1'b0;
            p7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (p1_adv)  p1_valid_reg  <= s_axis_tvalid;
            if (p2_adv)  p2_valid_reg  <= p1_valid_reg;
            if (p3_adv)  p3_valid_reg  <= p2_valid_reg;
            if (p4_adv)  p4_valid_reg  <= p3_valid_reg && (p3_reg.op == OP_DEFORM);
            if (p5_adv)  p5_valid_reg  <= p4_valid_reg;
            if (p6_adv)  p6_valid_reg  <= p5_valid_reg;
            if (p7_adv)  p7_valid_reg  <= p6_valid_reg;
            if (out_adv) out_valid_reg <= p7_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (p1_adv)  p1_reg       <= p1_next;
        if (p2_adv)  p2_reg       <= p2_next;
        if (p3_adv)  p3_reg       <= p3_next;
        if (p4_adv)  p4_reg       <= p4_next;
        if (p5_adv)  p5_reg       <= p5_next;
        if (p6_adv)  p6_reg       <= p6_next;
        if (p7_adv)  p7_reg       <= p7_next;
        if (out_adv) out_data_reg <= out_data_next;
    end

    // Stage 1: unpack the item and clamp u and v to one.
    always_comb begin
        logic [COORD_W-1:0] u_in;
        logic [COORD_W-1:0] v_in;
        u_in          = s_axis_tdata[TD_U_LSB +: COORD_W];
        v_in          = s_axis_tdata[TD_V_LSB +: COORD_W];
        p1_next.op    = op_t'(s_axis_tuser);
        p1_next.pidx  = s_axis_tdata[TD_PIDX_LSB +: PIDX_W];
        p1_next.ofs_x = s_axis_tdata[TD_OFSX_LSB +: OFS_W];
        p1_next.ofs_y = s_axis_tdata[TD_OFSY_LSB +: OFS_W];
        p1_next.pos_x = s_axis_tdata[TD_POSX_LSB +: POS_W];
        p1_next.pos_y = s_axis_tdata[TD_POSY_LSB +: POS_W];
        p1_next.u     = (u_in > COORD_W'(Q16_ONE)) ? COORD_W'(Q16_ONE) : u_in;
        p1_next.v     = (v_in > COORD_W'(Q16_ONE)) ? COORD_W'(Q16_ONE) : v_in;
    end

    // Stage 2: scale u and v onto the grid; check the write index against the grid size.
    always_comb begin
        p2_next.op    = p1_reg.op;
        p2_next.pidx  = p1_reg.pidx;
        p2_next.ofs_x = p1_reg.ofs_x;
        p2_next.ofs_y = p1_reg.ofs_y;
        p2_next.pos_x = p1_reg.pos_x;
        p2_next.pos_y = p1_reg.pos_y;
        p2_next.wr_ok = (WR_CMP_W'(p1_reg.pidx) < WR_CMP_W'(cell_count));
        p2_next.fx    = FX_W'(p1_reg.u) * FX_W'(cols_m1);
        p2_next.fy    = FY_W'(p1_reg.v) * FY_W'(rows_m1);
    end

    // Stage 3: split into cell and fraction, and form the four neighbor indexes.
    always_comb begin
        logic [COL_W-1:0] x0;
        logic [COL_W-1:0] x1;
        logic [ROW_W-1:0] y0;
        logic [ROW_W-1:0] y1;
        logic [COL_W:0]   x0p1;
        logic [ROW_W:0]   y0p1;
        logic [CELL_W-1:0] row0;
        logic [CELL_W-1:0] row1;
        x0   = p2_reg.fx[FRAC_W +: COL_W];
        y0   = p2_reg.fy[FRAC_W +: ROW_W];
        x0p1 = {1'b0, x0} + (COL_W+1)'(1);
        y0p1 = {1'b0, y0} + (ROW_W+1)'(1);
        x1   = (x0p1 < {1'b0, cols_eff}) ? x0p1[COL_W-1:0] : cols_m1;
        y1   = (y0p1 < {1'b0, rows_eff}) ? y0p1[ROW_W-1:0] : rows_m1;
        row0 = CELL_W'(y0) * CELL_W'(cols_eff);
        row1 = CELL_W'(y1) * CELL_W'(cols_eff);
        p3_next.op     = p2_reg.op;
        p3_next.pidx   = p2_reg.pidx;
        p3_next.ofs_x  = p2_reg.ofs_x;
        p3_next.ofs_y  = p2_reg.ofs_y;
        p3_next.wr_ok  = p2_reg.wr_ok;
        p3_next.pos_x  = p2_reg.pos_x;
        p3_next.pos_y  = p2_reg.pos_y;
        p3_next.tx     = p2_reg.fx[FRAC_W-1:0];
        p3_next.ty     = p2_reg.fy[FRAC_W-1:0];
        p3_next.idx[0] = IDX_W'(row0 + CELL_W'(x0));
        p3_next.idx[1] = IDX_W'(row0 + CELL_W'(x1));
        p3_next.idx[2] = IDX_W'(row1 + CELL_W'(x0));
        p3_next.idx[3] = IDX_W'(row1 + CELL_W'(x1));
    end

    // Memory stage: writes, clears and the four neighbor reads happen in stream order.
    assign p3_waddr   = p3_reg.pidx[ADDR_W-1:0];
    assign wr_entry   = {p3_reg.ofs_y, p3_reg.ofs_x};
    assign write_fire = p4_adv && p3_valid_reg && (p3_reg.op == OP_WRITE) && p3_reg.wr_ok;
    assign clear_fire = p4_adv && p3_valid_reg && (p3_reg.op == OP_CLEAR);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rd_addr[k]     = p3_reg.idx[k][ADDR_W-1:0];
            rd_in_range[k] = ((IDX_W+1)'(p3_reg.idx[k]) < (IDX_W+1)'(DEPTH));
        end
    end

    // Both grid copies take every write; each serves two of the four neighbor reads.
    always_ff @(posedge aclk) begin
        if (write_fire) begin
            grid_mem_a[p3_waddr] <= wr_entry;
            grid_mem_b[p3_waddr] <= wr_entry;
        end
        if (p4_adv) begin
            rd_reg[0] <= grid_mem_a[rd_addr[0]];
            rd_reg[1] <= grid_mem_a[rd_addr[1]];
            rd_reg[2] <= grid_mem_b[rd_addr[2]];
            rd_reg[3] <= grid_mem_b[rd_addr[3]];
        end
    end

    // An entry counts only once written since the last clear.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_valid_reg <= '0;
        end else if (size_wr || clear_fire) begin
            grid_valid_reg <= '0;
        end else if (write_fire) begin
            grid_valid_reg[p3_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (p4_adv) begin
            for (int k = 0; k < 4; k++) begin
                hit_reg[k] <= grid_valid_reg[rd_addr[k]] && rd_in_range[k];
            end
        end
    end

    assign p4_next.pos_x = p3_reg.pos_x;
    assign p4_next.pos_y = p3_reg.pos_y;
    assign p4_next.tx    = p3_reg.tx;
    assign p4_next.ty    = p3_reg.ty;

    // Stage 5: entries not written since the last clear read as zero; blend along x.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            nb_x[k] = hit_reg[k] ? rd_reg[k][OFS_W-1:0]     : '0;
            nb_y[k] = hit_reg[k] ? rd_reg[k][ENTRY_W-1:OFS_W] : '0;
        end
    end

    always_comb begin
        p5_next.pos_x = p4_reg.pos_x;
        p5_next.pos_y = p4_reg.pos_y;
        p5_next.ty    = p4_reg.ty;
        p5_next.ax    = blend_h(nb_x[0], nb_x[1], p4_reg.tx);
        p5_next.bx    = blend_h(nb_x[2], nb_x[3], p4_reg.tx);
        p5_next.ay    = blend_h(nb_y[0], nb_y[1], p4_reg.tx);
        p5_next.by    = blend_h(nb_y[2], nb_y[3], p4_reg.tx);
    end

    // Stage 6: blend along y.
    always_comb begin
        p6_next.pos_x = p5_reg.pos_x;
        p6_next.pos_y = p5_reg.pos_y;
        p6_next.dx    = blend_v(p5_reg.ax, p5_reg.bx, p5_reg.ty);
        p6_next.dy    = blend_v(p5_reg.ay, p5_reg.by, p5_reg.ty);
    end

    // Stage 7: scale by the weight; a zero weight gives a zero offset.
    always_comb begin
        p7_next.pos_x   = p6_reg.pos_x;
        p7_next.pos_y   = p6_reg.pos_y;
        p7_next.delta_x = apply_weight(p6_reg.dx, weight_eff);
        p7_next.delta_y = apply_weight(p6_reg.dy, weight_eff);
    end

    // Output register: saturating add of the offset to the position.
    assign out_data_next = {add_sat(p7_reg.pos_y, p7_reg.delta_y),
                            add_sat(p7_reg.pos_x, p7_reg.delta_x)};

    // Checks on grid state and the ready chain.
    `FFD_ASSERT_NEXT(a_clear_item_empties_grid, aclk, aresetn, clear_fire, grid_valid_reg == '0)
    `FFD_ASSERT_NEXT(a_size_write_empties_grid, aclk, aresetn, size_wr, grid_valid_reg == '0)
    `FFD_ASSERT_NEXT(a_point_write_marks_entry, aclk, aresetn, write_fire && !size_wr, grid_valid_reg[$past(p3_waddr)])
    `FFD_ASSERT_IMPL(a_stall_only_when_full, aclk, aresetn, !s_axis_tready, out_valid_reg && !m_axis_tready && p1_valid_reg && p4_valid_reg && p7_valid_reg)

endmodule
